// ===== hw/rtl/ppe_pkg.sv =====
// shared types and constants of the polygon prism extruder
// no dependencies; used by every module of the block by scoped name
package ppe_pkg;

	// coordinate and field widths
	localparam int COORD_WIDTH  = 16;
	localparam int HEIGHT_WIDTH = 16;
	localparam int SHADE_WIDTH  = 8;
	localparam int RING_WIDTH   = 5;
	localparam int CMD_WIDTH    = 2;

	// stream word widths, padded to whole bytes; cmd travels on tuser
	localparam int IN_BITS    = 2 * COORD_WIDTH;
	localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS   = 5 * COORD_WIDTH + HEIGHT_WIDTH + SHADE_WIDTH;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	// configuration port
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	// ring size limits
	localparam int RING_MIN = 3;
	localparam int RING_MAX = 16;

	// edge job queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// vertex counter inside one edge
	localparam int VTX_IDX_W = 3;

	// unit normal in Q1.14
	localparam int ONE_Q14 = 16384;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef enum logic [CMD_WIDTH-1:0] {
		CMD_TOP    = 2'd0,
		CMD_BOTTOM = 2'd1,
		CMD_WALL   = 2'd2,
		CMD_SKIP   = 2'd3
	} cmd_t;

	// register indexes on the configuration port (word address)
	typedef enum logic [2:0] {
		REG_RING_POINTS  = 3'd0,
		REG_PRISM_HEIGHT = 3'd1,
		REG_TOP_GRAY     = 3'd2,
		REG_BOTTOM_GRAY  = 3'd3,
		REG_FRONT_GRAY   = 3'd4,
		REG_SIDE_GRAY    = 3'd5
	} reg_idx_t;

	// one accepted point: its edge from the previous point, and the wrap edge if it closes
	typedef struct packed {
		cmd_t   cmd;
		coord_t prev_x;
		coord_t prev_z;
		coord_t cur_x;
		coord_t cur_z;
		coord_t first_x;
		coord_t first_z;
		logic   wrap;
	} edge_job_t;

	// settings seen by the vertex generator
	typedef struct packed {
		logic [HEIGHT_WIDTH-1:0] height;
		logic [SHADE_WIDTH-1:0]  top_gray;
		logic [SHADE_WIDTH-1:0]  bottom_gray;
		logic [SHADE_WIDTH-1:0]  front_gray;
		logic [SHADE_WIDTH-1:0]  side_gray;
	} cfg_t;

endpackage

// ===== hw/rtl/polygon_prism_extruder_core.sv =====
// Polygon prism extruder top level: configuration registers, front end, job queue, back end.
// An edge job goes into the queue (4 points deep), then into the back-end edge registers, and its first
// vertex word leaves the output register. One vertex word per cycle unless m_tready is low or no job
// waits; but for a ring's first, a cap point makes 3 words, a wall point 6, a closing point twice that.
// Reset (arst_n, async): clears ring position, queue and output valid, restores register defaults.
// Depends on ppe_pkg, ppe_front, ppe_queue, ppe_back.
module polygon_prism_extruder_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [ppe_pkg::IN_DATA_W-1:0]      s_tdata,   // point_x, point_z
	input  logic [ppe_pkg::CMD_WIDTH-1:0]      s_tuser,   // cmd
	// output stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [ppe_pkg::OUT_DATA_W-1:0]     m_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, gray
	output logic                               m_tlast,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [ppe_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [ppe_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [ppe_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);

	localparam int DW = ppe_pkg::APB_DATA_W;

	logic [ppe_pkg::RING_WIDTH-1:0]   ring_points_q;
	logic [ppe_pkg::HEIGHT_WIDTH-1:0] prism_height_q;
	logic [ppe_pkg::SHADE_WIDTH-1:0]  top_gray_q;
	logic [ppe_pkg::SHADE_WIDTH-1:0]  bottom_gray_q;
	logic [ppe_pkg::SHADE_WIDTH-1:0]  front_gray_q;
	logic [ppe_pkg::SHADE_WIDTH-1:0]  side_gray_q;
	ppe_pkg::reg_idx_t                reg_idx;
	logic                             reg_wr;
	ppe_pkg::cfg_t                    cfg;
	logic                             push;
	logic                             pop;
	logic                             q_full;
	logic                             head_valid;
	ppe_pkg::edge_job_t               job;
	ppe_pkg::edge_job_t               head;

	assign pready  = 1'b1;
	assign reg_idx = ppe_pkg::reg_idx_t'(paddr[4:2]);
	assign reg_wr  = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_points_q  <= ppe_pkg::RING_WIDTH'(4);
			prism_height_q <= ppe_pkg::HEIGHT_WIDTH'(9830);
			top_gray_q     <= ppe_pkg::SHADE_WIDTH'(255);
			bottom_gray_q  <= ppe_pkg::SHADE_WIDTH'(64);
			front_gray_q   <= ppe_pkg::SHADE_WIDTH'(200);
			side_gray_q    <= ppe_pkg::SHADE_WIDTH'(128);
		end else if (reg_wr) begin
			unique case (reg_idx)
				ppe_pkg::REG_RING_POINTS:  ring_points_q  <= pwdata[ppe_pkg::RING_WIDTH-1:0];
				ppe_pkg::REG_PRISM_HEIGHT: prism_height_q <= pwdata[ppe_pkg::HEIGHT_WIDTH-1:0];
				ppe_pkg::REG_TOP_GRAY:     top_gray_q     <= pwdata[ppe_pkg::SHADE_WIDTH-1:0];
				ppe_pkg::REG_BOTTOM_GRAY:  bottom_gray_q  <= pwdata[ppe_pkg::SHADE_WIDTH-1:0];
				ppe_pkg::REG_FRONT_GRAY:   front_gray_q   <= pwdata[ppe_pkg::SHADE_WIDTH-1:0];
				ppe_pkg::REG_SIDE_GRAY:    side_gray_q    <= pwdata[ppe_pkg::SHADE_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// register read-back
	always_comb begin
		unique case (reg_idx)
			ppe_pkg::REG_RING_POINTS:  prdata = DW'(ring_points_q);
			ppe_pkg::REG_PRISM_HEIGHT: prdata = DW'(prism_height_q);
			ppe_pkg::REG_TOP_GRAY:     prdata = DW'(top_gray_q);
			ppe_pkg::REG_BOTTOM_GRAY:  prdata = DW'(bottom_gray_q);
			ppe_pkg::REG_FRONT_GRAY:   prdata = DW'(front_gray_q);
			ppe_pkg::REG_SIDE_GRAY:    prdata = DW'(side_gray_q);
			default:                   prdata = '0;
		endcase
	end

	always_comb begin
		cfg.height      = prism_height_q;
		cfg.top_gray    = top_gray_q;
		cfg.bottom_gray = bottom_gray_q;
		cfg.front_gray  = front_gray_q;
		cfg.side_gray   = side_gray_q;
	end

	ppe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.ring_points (ring_points_q),
		.q_full      (q_full),
		.push        (push),
		.job         (job)
	);

	ppe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.job_in     (job),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (q_full)
	);

	ppe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

// ===== hw/rtl/ppe_front.sv =====
// front end: accepts ring points, tracks first/previous point and ring position
// depends on ppe_pkg; feeds edge jobs to ppe_queue
module ppe_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [ppe_pkg::IN_DATA_W-1:0]     s_tdata,   // point_x, point_z
	input  logic [ppe_pkg::CMD_WIDTH-1:0]     s_tuser,   // cmd
	input  logic [ppe_pkg::RING_WIDTH-1:0]    ring_points,
	input  logic                              q_full,
	output logic                              push,
	output ppe_pkg::edge_job_t                job
);

	ppe_pkg::cmd_t                   cmd;
	ppe_pkg::coord_t                 pt_x;
	ppe_pkg::coord_t                 pt_z;
	logic                            accept;
	logic                            live;
	logic                            closes;
	logic [ppe_pkg::RING_WIDTH-1:0]  ring_n;
	logic [ppe_pkg::RING_WIDTH-1:0]  count_q;
	ppe_pkg::coord_t                 first_x_q;
	ppe_pkg::coord_t                 first_z_q;
	ppe_pkg::coord_t                 prev_x_q;
	ppe_pkg::coord_t                 prev_z_q;

	// unpack the input word
	assign cmd  = ppe_pkg::cmd_t'(s_tuser);
	assign pt_x = s_tdata[0 +: ppe_pkg::COORD_WIDTH];
	assign pt_z = s_tdata[ppe_pkg::COORD_WIDTH +: ppe_pkg::COORD_WIDTH];

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign live     = accept && (cmd != ppe_pkg::CMD_SKIP);

	// clamp ring size to the supported range
	always_comb begin
		if (ring_points < ppe_pkg::RING_WIDTH'(ppe_pkg::RING_MIN)) begin
			ring_n = ppe_pkg::RING_WIDTH'(ppe_pkg::RING_MIN);
		end else if (ring_points > ppe_pkg::RING_WIDTH'(ppe_pkg::RING_MAX)) begin
			ring_n = ppe_pkg::RING_WIDTH'(ppe_pkg::RING_MAX);
		end else begin
			ring_n = ring_points;
		end
	end

	assign closes = count_q >= (ring_n - ppe_pkg::RING_WIDTH'(1));

	// every point but the first of a ring makes at least one edge
	assign push = live && (count_q != '0);

	always_comb begin
		job.cmd     = cmd;
		job.prev_x  = prev_x_q;
		job.prev_z  = prev_z_q;
		job.cur_x   = pt_x;
		job.cur_z   = pt_z;
		job.first_x = first_x_q;
		job.first_z = first_z_q;
		job.wrap    = closes;
	end

	// ring position and counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (live) begin
			if (closes) begin
				count_q <= '0;
			end else begin
				count_q <= count_q + ppe_pkg::RING_WIDTH'(1);
			end
		end
	end

	// first and previous point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q <= '0;
			first_z_q <= '0;
			prev_x_q  <= '0;
			prev_z_q  <= '0;
		end else if (live) begin
			if (count_q == '0) begin
				first_x_q <= pt_x;
				first_z_q <= pt_z;
			end
			prev_x_q <= pt_x;
			prev_z_q <= pt_z;
		end
	end

endmodule

// ===== hw/rtl/ppe_queue.sv =====
// short queue of edge jobs between the front end and the vertex generator
// depends on ppe_pkg
module ppe_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ppe_pkg::edge_job_t job_in,
	input  logic               pop,
	output ppe_pkg::edge_job_t head,
	output logic               head_valid,
	output logic               full
);

	ppe_pkg::edge_job_t               mem_q [ppe_pkg::QUEUE_DEPTH];
	logic [ppe_pkg::QUEUE_PTR_W-1:0]  wr_ptr_q;
	logic [ppe_pkg::QUEUE_PTR_W-1:0]  rd_ptr_q;
	logic [ppe_pkg::QUEUE_CNT_W-1:0]  cnt_q;

	assign head       = mem_q[rd_ptr_q];
	assign head_valid = cnt_q != '0;
	assign full       = cnt_q == ppe_pkg::QUEUE_CNT_W'(ppe_pkg::QUEUE_DEPTH);

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= job_in;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + ppe_pkg::QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ppe_pkg::QUEUE_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + ppe_pkg::QUEUE_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - ppe_pkg::QUEUE_CNT_W'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/ppe_back.sv =====
// back end: turns edge jobs into cap or wall vertices, one vertex word per cycle
// unless m_tready is low or no edge waits; depends on ppe_pkg; reads jobs from ppe_queue
module ppe_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ppe_pkg::cfg_t                     cfg,
	input  ppe_pkg::edge_job_t                head,
	input  logic                              head_valid,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [ppe_pkg::OUT_DATA_W-1:0]    m_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, gray
	output logic                              m_tlast
);

	localparam int CW  = ppe_pkg::COORD_WIDTH;
	localparam int PW  = 2 * CW;
	localparam logic [ppe_pkg::VTX_IDX_W-1:0] VTX_LAST_CAP  = ppe_pkg::VTX_IDX_W'(2);
	localparam logic [ppe_pkg::VTX_IDX_W-1:0] VTX_LAST_WALL = ppe_pkg::VTX_IDX_W'(5);
	localparam ppe_pkg::coord_t NORM_UP   = CW'(ppe_pkg::ONE_Q14);
	localparam ppe_pkg::coord_t NORM_DOWN = -NORM_UP;

	// edge under work
	logic                             busy_q;
	logic                             wrap_pending_q;
	logic                             last_edge_q;
	ppe_pkg::cmd_t                    cmd_q;
	logic [ppe_pkg::VTX_IDX_W-1:0]    idx_q;
	ppe_pkg::coord_t                  ax_q, az_q, bx_q, bz_q;
	ppe_pkg::coord_t                  mx_q, mz_q;
	logic                             front_q;
	logic signed [PW-1:0]             p1_q, p2_q;
	ppe_pkg::coord_t                  hold_x_q, hold_z_q, hold_fx_q, hold_fz_q;
	ppe_pkg::cmd_t                    hold_cmd_q;

	// output register
	logic                             m_valid_q;
	logic                             m_last_q;
	ppe_pkg::coord_t                  o_px_q, o_pz_q, o_nx_q, o_ny_q, o_nz_q;
	logic [ppe_pkg::HEIGHT_WIDTH-1:0] o_py_q;
	logic [ppe_pkg::SHADE_WIDTH-1:0]  o_gray_q;

	logic                             fire;
	logic                             at_end;
	logic                             take;
	logic                             from_wrap;
	logic                             from_queue;
	logic [ppe_pkg::VTX_IDX_W-1:0]    final_idx;
	ppe_pkg::cmd_t                    src_cmd;
	ppe_pkg::coord_t                  src_ax, src_az, src_bx, src_bz;
	logic                             src_last;
	logic signed [CW:0]               sum_x, sum_z;
	logic                             pos, nonneg;
	logic                             sel_b, sel_c, high;
	ppe_pkg::coord_t                  v_px, v_pz, v_nx, v_ny, v_nz;
	logic [ppe_pkg::HEIGHT_WIDTH-1:0] v_py;
	logic [ppe_pkg::SHADE_WIDTH-1:0]  v_gray;

	// handshake and sequencing
	assign final_idx  = (cmd_q == ppe_pkg::CMD_WALL) ? VTX_LAST_WALL : VTX_LAST_CAP;
	assign fire       = busy_q && (!m_valid_q || m_tready);
	assign at_end     = fire && (idx_q == final_idx);
	assign take       = !busy_q || at_end;
	assign from_wrap  = take && wrap_pending_q;
	assign from_queue = take && !wrap_pending_q && head_valid;
	assign pop        = from_queue;

	// next edge: wrap edge of the held point, else the main edge at the queue head
	always_comb begin
		if (wrap_pending_q) begin
			src_cmd  = hold_cmd_q;
			src_ax   = hold_x_q;
			src_az   = hold_z_q;
			src_bx   = hold_fx_q;
			src_bz   = hold_fz_q;
			src_last = 1'b1;
		end else begin
			src_cmd  = head.cmd;
			src_ax   = head.prev_x;
			src_az   = head.prev_z;
			src_bx   = head.cur_x;
			src_bz   = head.cur_z;
			src_last = !head.wrap;
		end
	end

	assign sum_x = {src_ax[CW-1], src_ax} + {src_bx[CW-1], src_bx};
	assign sum_z = {src_az[CW-1], src_az} + {src_bz[CW-1], src_bz};

	// edge load: operands, cross products and midpoint normal
	always_ff @(posedge clk) begin
		if (from_wrap || from_queue) begin
			cmd_q       <= src_cmd;
			ax_q        <= src_ax;
			az_q        <= src_az;
			bx_q        <= src_bx;
			bz_q        <= src_bz;
			last_edge_q <= src_last;
			p1_q        <= src_ax * src_bz;
			p2_q        <= src_az * src_bx;
			mx_q        <= sum_x[CW:1];
			mz_q        <= sum_z[CW:1];
			front_q     <= sum_z[CW];
		end
		if (from_queue) begin
			hold_cmd_q <= head.cmd;
			hold_x_q   <= head.cur_x;
			hold_z_q   <= head.cur_z;
			hold_fx_q  <= head.first_x;
			hold_fz_q  <= head.first_z;
		end
	end

	// control of the edge sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			wrap_pending_q <= 1'b0;
			idx_q          <= '0;
		end else begin
			if (take) begin
				busy_q <= from_wrap || from_queue;
			end
			if (from_queue) begin
				wrap_pending_q <= head.wrap;
			end else if (from_wrap) begin
				wrap_pending_q <= 1'b0;
			end
			if (take) begin
				idx_q <= '0;
			end else if (fire) begin
				idx_q <= idx_q + ppe_pkg::VTX_IDX_W'(1);
			end
		end
	end

	// winding from the cross product
	assign pos    = p1_q > p2_q;
	assign nonneg = p1_q >= p2_q;

	// vertex decoder: center, a or b, and top or bottom height
	always_comb begin
		sel_b = 1'b0;
		sel_c = 1'b0;
		high  = 1'b0;
		unique case (cmd_q)
			ppe_pkg::CMD_TOP: begin
				high = 1'b1;
				case (idx_q)
					3'd0:    sel_c = 1'b1;
					3'd1:    sel_b = pos;
					default: sel_b = !pos;
				endcase
			end
			ppe_pkg::CMD_BOTTOM: begin
				case (idx_q)
					3'd0:    sel_c = 1'b1;
					3'd1:    sel_b = !pos;
					default: sel_b = pos;
				endcase
			end
			ppe_pkg::CMD_WALL: begin
				if (nonneg) begin
					case (idx_q) inside
						3'd1:       high = 1'b1;
						3'd2, 3'd4: begin
							high  = 1'b1;
							sel_b = 1'b1;
						end
						3'd5:       sel_b = 1'b1;
						default:    sel_b = 1'b0;
					endcase
				end else begin
					case (idx_q) inside
						3'd1, 3'd5: begin
							high  = 1'b1;
							sel_b = 1'b1;
						end
						3'd2:       high = 1'b1;
						3'd4:       sel_b = 1'b1;
						default:    sel_b = 1'b0;
					endcase
				end
			end
			default: sel_c = 1'b1;
		endcase
	end

	// vertex fields
	always_comb begin
		if (sel_c) begin
			v_px = '0;
			v_pz = '0;
		end else if (sel_b) begin
			v_px = bx_q;
			v_pz = bz_q;
		end else begin
			v_px = ax_q;
			v_pz = az_q;
		end
		v_py = high ? cfg.height : '0;
		unique case (cmd_q)
			ppe_pkg::CMD_TOP: begin
				v_nx   = '0;
				v_ny   = NORM_UP;
				v_nz   = '0;
				v_gray = cfg.top_gray;
			end
			ppe_pkg::CMD_BOTTOM: begin
				v_nx   = '0;
				v_ny   = NORM_DOWN;
				v_nz   = '0;
				v_gray = cfg.bottom_gray;
			end
			default: begin
				v_nx   = mx_q;
				v_ny   = '0;
				v_nz   = mz_q;
				v_gray = front_q ? cfg.front_gray : cfg.side_gray;
			end
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fire) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			o_px_q   <= v_px;
			o_py_q   <= v_py;
			o_pz_q   <= v_pz;
			o_nx_q   <= v_nx;
			o_ny_q   <= v_ny;
			o_nz_q   <= v_nz;
			o_gray_q <= v_gray;
			m_last_q <= last_edge_q && (idx_q == final_idx);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = ppe_pkg::OUT_DATA_W'({o_gray_q, o_nz_q, o_ny_q, o_nx_q,
		o_pz_q, o_py_q, o_px_q});

`ifndef NO_ASSERTIONS
	a_wrap_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wrap_pending_q |-> busy_q)
		else $error("wrap edge pending while sequencer idle");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= final_idx)
		else $error("vertex index beyond end of edge");

	a_wrap_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		wrap_pending_q |-> !last_edge_q)
		else $error("main edge marked last while wrap edge follows");
`endif

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench of polygon_prism_extruder_core: predicts every vertex word of each ring point
// depends on ppe_pkg and polygon_prism_extruder_core from hw/rtl
`timescale 1ns / 100ps

module testbench;
	import ppe_pkg::*;

	localparam int NUM_REGS     = 6;
	localparam int MAX_GAP      = 17;
	localparam int DRAIN_CYCLES = 24;
	localparam int PHASE_POINTS = 44;
	localparam int NUM_PHASES   = 6;
	localparam coord_t NORM_UP   = coord_t'(ONE_Q14);
	localparam coord_t NORM_DOWN = coord_t'(-ONE_Q14);

	// one vertex word as seen on the output stream
	typedef struct packed {
		coord_t      pos_x;
		logic [15:0] pos_y;
		coord_t      pos_z;
		coord_t      norm_x;
		coord_t      norm_y;
		coord_t      norm_z;
		logic [7:0]  gray;
		logic        last;
	} vertex_t;

	// prism predictor and store of vertices still to come
	class prism_scoreboard;
		logic [4:0]  ring_reg;
		logic [15:0] height_reg;
		logic [7:0]  top_reg, bottom_reg, front_reg, side_reg;
		coord_t      first_x, first_z, prev_x, prev_z;
		logic [4:0]  point_idx;
		vertex_t     vertex_q[$];
		int          failures;
		int          vertices_seen;
		int          points_seen;

		function new();
			ring_reg   = 5'd4;
			height_reg = 16'd9830;
			top_reg    = 8'd255;
			bottom_reg = 8'd64;
			front_reg  = 8'd200;
			side_reg   = 8'd128;
			first_x    = '0;
			first_z    = '0;
			prev_x     = '0;
			prev_z     = '0;
			point_idx  = '0;
			failures   = 0;
			vertices_seen = 0;
			points_seen   = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] value);
			case (idx)
				REG_RING_POINTS:  ring_reg   = value[4:0];
				REG_PRISM_HEIGHT: height_reg = value[15:0];
				REG_TOP_GRAY:     top_reg    = value[7:0];
				REG_BOTTOM_GRAY:  bottom_reg = value[7:0];
				REG_FRONT_GRAY:   front_reg  = value[7:0];
				REG_SIDE_GRAY:    side_reg   = value[7:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] reg_value(reg_idx_t idx);
			case (idx)
				REG_RING_POINTS:  return {27'd0, ring_reg};
				REG_PRISM_HEIGHT: return {16'd0, height_reg};
				REG_TOP_GRAY:     return {24'd0, top_reg};
				REG_BOTTOM_GRAY:  return {24'd0, bottom_reg};
				REG_FRONT_GRAY:   return {24'd0, front_reg};
				default:          return {24'd0, side_reg};
			endcase
		endfunction

		// ring size as used, clamped to the legal range
		function int ring_size();
			int n;
			n = ring_reg;
			if (n < RING_MIN) n = RING_MIN;
			if (n > RING_MAX) n = RING_MAX;
			return n;
		endfunction

		function void fail(string what);
			failures++;
			if (failures <= 10) $display("MISMATCH %s", what);
		endfunction

		function void push_vertex(coord_t x, logic [15:0] y, coord_t z, coord_t nx, coord_t ny,
				coord_t nz, logic [7:0] g);
			vertex_t v;
			v.pos_x  = x;
			v.pos_y  = y;
			v.pos_z  = z;
			v.norm_x = nx;
			v.norm_y = ny;
			v.norm_z = nz;
			v.gray   = g;
			v.last   = 1'b0;
			vertex_q.push_back(v);
		endfunction

		// vertices of one edge a->b in the pass kind of the point's command
		function void add_edge(cmd_t c, coord_t ax, coord_t az, coord_t bx, coord_t bz);
			longint p1, p2;
			bit pos, nonneg;
			int sx, sz;
			coord_t mx, mz;
			logic [7:0] g;
			logic [15:0] h;
			p1 = longint'(ax) * longint'(bz);
			p2 = longint'(az) * longint'(bx);
			pos = p1 > p2;
			nonneg = p1 >= p2;
			h = height_reg;
			case (c)
				CMD_TOP: begin
					push_vertex('0, h, '0, '0, NORM_UP, '0, top_reg);
					if (pos) begin
						push_vertex(bx, h, bz, '0, NORM_UP, '0, top_reg);
						push_vertex(ax, h, az, '0, NORM_UP, '0, top_reg);
					end else begin
						push_vertex(ax, h, az, '0, NORM_UP, '0, top_reg);
						push_vertex(bx, h, bz, '0, NORM_UP, '0, top_reg);
					end
				end
				CMD_BOTTOM: begin
					push_vertex('0, '0, '0, '0, NORM_DOWN, '0, bottom_reg);
					if (pos) begin
						push_vertex(ax, '0, az, '0, NORM_DOWN, '0, bottom_reg);
						push_vertex(bx, '0, bz, '0, NORM_DOWN, '0, bottom_reg);
					end else begin
						push_vertex(bx, '0, bz, '0, NORM_DOWN, '0, bottom_reg);
						push_vertex(ax, '0, az, '0, NORM_DOWN, '0, bottom_reg);
					end
				end
				default: begin
					// wall: midpoint normal floors, shade by sign of the z sum
					sx = int'(ax) + int'(bx);
					sz = int'(az) + int'(bz);
					mx = coord_t'(sx >>> 1);
					mz = coord_t'(sz >>> 1);
					g = (sz < 0) ? front_reg : side_reg;
					if (nonneg) begin
						push_vertex(ax, '0, az, mx, '0, mz, g);
						push_vertex(ax, h, az, mx, '0, mz, g);
						push_vertex(bx, h, bz, mx, '0, mz, g);
						push_vertex(ax, '0, az, mx, '0, mz, g);
						push_vertex(bx, h, bz, mx, '0, mz, g);
						push_vertex(bx, '0, bz, mx, '0, mz, g);
					end else begin
						push_vertex(ax, '0, az, mx, '0, mz, g);
						push_vertex(bx, h, bz, mx, '0, mz, g);
						push_vertex(ax, h, az, mx, '0, mz, g);
						push_vertex(ax, '0, az, mx, '0, mz, g);
						push_vertex(bx, '0, bz, mx, '0, mz, g);
						push_vertex(bx, h, bz, mx, '0, mz, g);
					end
				end
			endcase
		endfunction

		// accepted point word: advance the ring and queue its vertices
		function void note_point(cmd_t c, coord_t x, coord_t z);
			int n, before_cnt;
			vertex_t tail;
			if (c == CMD_SKIP) return;
			points_seen++;
			n = ring_size();
			before_cnt = vertex_q.size();
			if (point_idx == 0) begin
				first_x = x;
				first_z = z;
			end else begin
				add_edge(c, prev_x, prev_z, x, z);
			end
			if (int'(point_idx) >= n - 1) begin
				add_edge(c, x, z, first_x, first_z);
				point_idx = '0;
			end else begin
				point_idx = point_idx + 5'd1;
			end
			prev_x = x;
			prev_z = z;
			if (vertex_q.size() > before_cnt) begin
				tail = vertex_q.pop_back();
				tail.last = 1'b1;
				vertex_q.push_back(tail);
			end
		endfunction

		// accepted vertex word against the oldest prediction
		function void check_vertex(vertex_t got);
			vertex_t want;
			vertices_seen++;
			if (vertex_q.size() == 0) begin
				fail($sformatf("unexpected vertex pos %0d/%0d/%0d", got.pos_x, got.pos_y,
					got.pos_z));
				return;
			end
			want = vertex_q.pop_front();
			if (got !== want)
				fail($sformatf({"vertex %0d: exp pos %0d/%0d/%0d nrm %0d/%0d/%0d g %0d l %0d, ",
					"got pos %0d/%0d/%0d nrm %0d/%0d/%0d g %0d l %0d"}, vertices_seen,
					want.pos_x, want.pos_y, want.pos_z, want.norm_x, want.norm_y, want.norm_z,
					want.gray, want.last, got.pos_x, got.pos_y, got.pos_z, got.norm_x,
					got.norm_y, got.norm_z, got.gray, got.last));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata;      // point_x, point_z
	logic [CMD_WIDTH-1:0] s_tuser;      // cmd
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;     // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, gray
	logic m_tlast;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	prism_scoreboard sb;
	bit src_idle;
	bit sink_idle;
	int sink_stall;
	int skip_words;
	int settings_used;

	polygon_prism_extruder_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// receiver stall, applied on the falling edge
	always @(negedge clk) begin
		if (sink_stall > 0) begin
			m_tready <= 1'b0;
			sink_stall <= sink_stall - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// sample vertex words on the rising edge
	always @(posedge clk) begin : sample_out
		vertex_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.pos_x  = m_tdata[15:0];
			got.pos_y  = m_tdata[31:16];
			got.pos_z  = m_tdata[47:32];
			got.norm_x = m_tdata[63:48];
			got.norm_y = m_tdata[79:64];
			got.norm_z = m_tdata[95:80];
			got.gray   = m_tdata[103:96];
			got.last   = m_tlast;
			sb.check_vertex(got);
			sink_stall = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
		end
	end

	// one point word through the input stream
	task automatic send_point(cmd_t c, coord_t x, coord_t z);
		int gap;
		gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= c;
		s_tdata <= IN_DATA_W'({z, x});
		do @(posedge clk); while (!s_tready);
		sb.note_point(c, x, z);
		if (c == CMD_SKIP) skip_words++;
	endtask

	task automatic apb_access(reg_idx_t idx, bit wr, logic [31:0] wdata, output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= APB_ADDR_W'(int'(idx) * 4);
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		if (wr) sb.write_reg(idx, wdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// stop sending, wait for every predicted vertex, then let trailing no-output jobs finish
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.vertex_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write all registers while idle and read each one back
	task automatic program_regs(logic [31:0] ring, logic [31:0] height, logic [31:0] top,
			logic [31:0] bottom, logic [31:0] front, logic [31:0] side);
		logic [31:0] vals [NUM_REGS];
		logic [31:0] rd;
		wait_drained();
		vals = '{ring, height, top, bottom, front, side};
		for (int i = 0; i < NUM_REGS; i++) apb_access(reg_idx_t'(i), 1'b1, vals[i], rd);
		for (int i = 0; i < NUM_REGS; i++) begin
			apb_access(reg_idx_t'(i), 1'b0, '0, rd);
			if (rd !== sb.reg_value(reg_idx_t'(i)))
				sb.fail($sformatf("register %0d read: exp %0d got %0d", i,
					sb.reg_value(reg_idx_t'(i)), rd));
		end
		settings_used++;
	endtask

	// mostly unit-range coordinates, sometimes any 16-bit value
	function automatic coord_t rand_coord();
		if ($urandom_range(0, 9) == 0) return coord_t'($urandom);
		return coord_t'(int'($urandom_range(0, 32768)) - 16384);
	endfunction

	// random rings with noise words, stray commands, repeats and broken rings
	task automatic run_phase(int num_points);
		int sent, n, len, pause_at, ring_no;
		cmd_t ring_cmd, c;
		coord_t x, z;
		sent = 0;
		ring_no = 0;
		pause_at = $urandom_range(0, 2);
		x = '0;
		z = '0;
		while (sent < num_points) begin
			src_idle = ($urandom_range(0, 3) != 0);
			sink_idle = ($urandom_range(0, 3) != 0);
			if (ring_no == pause_at)
				wait_drained();
			n = sb.ring_size();
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, n - 1) : n;
			ring_cmd = cmd_t'($urandom_range(0, 2));
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 15) == 0) send_point(CMD_SKIP, rand_coord(), rand_coord());
				c = ($urandom_range(0, 9) == 0) ? cmd_t'($urandom_range(0, 2)) : ring_cmd;
				if ($urandom_range(0, 11) != 0) begin
					x = rand_coord();
					z = rand_coord();
				end
				send_point(c, x, z);
				sent++;
			end
			ring_no++;
		end
	endtask

	// main sequence
	initial begin
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		src_idle = 1'b1;
		sink_idle = 1'b1;
		sink_stall = 0;
		skip_words = 0;
		settings_used = 1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// counter-clockwise top cap at the unit extremes, with an ignored word inside
		send_point(CMD_TOP, 16384, 0);
		send_point(CMD_TOP, 0, 16384);
		send_point(CMD_SKIP, -1, -1);
		send_point(CMD_TOP, -16384, 0);
		send_point(CMD_TOP, 0, -16384);
		// clockwise bottom cap
		send_point(CMD_BOTTOM, 16384, 0);
		send_point(CMD_BOTTOM, 0, -16384);
		send_point(CMD_BOTTOM, -16384, 0);
		send_point(CMD_BOTTOM, 0, 16384);
		// walls beyond the stated range, collinear and zero-length edges
		send_point(CMD_WALL, -32768, 32767);
		send_point(CMD_WALL, 32767, -32768);
		send_point(CMD_WALL, 0, 0);
		send_point(CMD_WALL, 0, 0);
		// mixed pass kinds within one ring
		send_point(CMD_WALL, 16384, 16384);
		send_point(CMD_TOP, -16384, 16384);
		send_point(CMD_BOTTOM, -16384, -16384);
		send_point(CMD_WALL, 16384, -16384);
		// repeated point: zero cross product on a cap
		send_point(CMD_TOP, 5, -7);
		send_point(CMD_TOP, 5, -7);
		send_point(CMD_TOP, -3, 1);
		send_point(CMD_TOP, -1, -1);

		// register settings: both extremes, then random ones
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: program_regs(0, 0, 0, 0, 0, 0);
				1: program_regs(31, 65535, 255, 255, 255, 255);
				2: program_regs(3, $urandom_range(0, 65535), $urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
				3: program_regs(16, $urandom_range(0, 65535), $urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
				default: program_regs($urandom_range(0, 31), $urandom_range(0, 65535),
					$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255));
			endcase
			run_phase(PHASE_POINTS);
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait_drained();
		if (sb.vertex_q.size() != 0)
			sb.fail($sformatf("%0d vertices never arrived", sb.vertex_q.size()));

		$display("run: %0d ring points and %0d ignored words over %0d register settings",
			sb.points_seen, skip_words, settings_used);
		$display("run: %0d vertex words checked, %0d failures", sb.vertices_seen, sb.failures);
		if (sb.failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/ppe_pkg.sv
hw/rtl/ppe_front.sv
hw/rtl/ppe_queue.sv
hw/rtl/ppe_back.sv
hw/rtl/polygon_prism_extruder_core.sv
verif/testbench.sv
